/* src/hashed_block_cache_lfu_unit_assert.svh */
// Assertion macros shared by the hashed block cache RTL.
// No dependencies; each file that asserts includes this header.
`ifndef HASHED_BLOCK_CACHE_LFU_UNIT_ASSERT_SVH
`define HASHED_BLOCK_CACHE_LFU_UNIT_ASSERT_SVH

// Implication checked on every rising edge outside reset.
`define HBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hbc assertion failed");

// Implication whose consequence is checked in the next cycle.
`define HBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hbc assertion failed");

`endif

/* src/hbc_pkg.sv */
// Package of the hashed block cache: sequencer states, mode and register codes,
// and the entry record. No dependencies.
`default_nettype none
package hbc_pkg;

	localparam logic [2:0] MODE_LOOKUP = 3'd0;
	localparam logic [2:0] MODE_ADD    = 3'd1;
	localparam logic [2:0] MODE_REMOVE = 3'd2;
	localparam logic [2:0] MODE_INV    = 3'd3;
	localparam logic [2:0] MODE_RESET  = 3'd4;

	localparam logic [3:0] CFG_HASH_SHIFT     = 4'd0;
	localparam logic [3:0] CFG_PROMOTE_MARGIN = 4'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HASH_A,
		ST_HASH_E,
		ST_META,
		ST_FAV,
		ST_SCAN,
		ST_DROP_RD,
		ST_DROP_WR,
		ST_INV_RD,
		ST_INV_CHK,
		ST_SWEEP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] handle;
		logic [31:0] uses;
	} entry_t;

endpackage
`default_nettype wire

/* src/hbc_hash.sv */
// Bucket index unit: shifts the address and reduces it modulo the bucket count.
// Depends on nothing; a power-of-two count is a registered mask, any other a bit-serial remainder.
`default_nettype none
module hbc_hash #(
	parameter int BUCKETS = 256,
	parameter int BW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [31:0]   value,
	input  wire logic [4:0]    shift,
	output logic               done,
	output logic [BW-1:0]      bucket
);

	localparam bit IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

	generate
		if (IS_POW2) begin : g_mask
			logic [31:0]   shifted;
			logic          done_q;
			logic [BW-1:0] bucket_q;

			assign shifted = value >> shift;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					bucket_q <= shifted[BW-1:0];
				end
			end

			assign done = done_q;
			assign bucket = bucket_q;
		end else begin : g_iter
			logic [31:0] sh_q;
			logic [BW:0] rem_q;
			logic [5:0]  cnt_q;
			logic        done_q;
			logic [BW:0] trial;

			assign trial = {rem_q[BW-1:0], sh_q[31]};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cnt_q <= 6'd0;
					done_q <= 1'b0;
				end else begin
					done_q <= 1'b0;
					if (start) begin
						cnt_q <= 6'd32;
					end else if (cnt_q != 6'd0) begin
						cnt_q <= cnt_q - 6'd1;
						done_q <= cnt_q == 6'd1;
					end
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					sh_q <= value >> shift;
					rem_q <= '0;
				end else if (cnt_q != 6'd0) begin
					sh_q <= {sh_q[30:0], 1'b0};
					if (trial >= (BW+1)'(BUCKETS)) begin
						rem_q <= trial - (BW+1)'(BUCKETS);
					end else begin
						rem_q <= trial;
					end
				end
			end

			assign done = done_q;
			assign bucket = rem_q[BW-1:0];
		end
	endgenerate

endmodule
`default_nettype wire

/* src/hashed_block_cache_lfu_unit.sv */
// Lookup, add and remove go one word at a time; the scan is bounded by the entry
// memory's single read port, one way per cycle. Range invalidate in one bucket reads
// and checks each way in turn; across buckets and reset all: one bucket per cycle.
// After reset a clearing pass over all buckets runs before the first word is accepted.
// A non-power-of-two BUCKETS makes each hash a bit-serial remainder.
`default_nettype none
`include "hashed_block_cache_lfu_unit_assert.svh"
module hashed_block_cache_lfu_unit #(
	parameter int BUCKETS = 256,
	parameter int WAYS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  mode,
	input  wire logic [31:0] addr,
	input  wire logic [31:0] end_addr,
	input  wire logic [31:0] code_handle,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             found,
	output logic             fast_hit,
	output logic [31:0]      code_out
);

	localparam int BW = $clog2(BUCKETS);
	localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int SW = $clog2(WAYS + 1);
	localparam int EDEPTH = BUCKETS * (2 ** WB);
	localparam logic [SW-1:0] NONE = SW'(WAYS);

	typedef struct packed {
		logic [SW-1:0] fill;
		logic [SW-1:0] fav;
	} meta_t;

	hbc_pkg::entry_t ent_mem [EDEPTH];
	meta_t           meta_mem [BUCKETS];

	hbc_pkg::state_t state_q, state_d;
	logic [4:0]      hash_shift_q;
	logic [7:0]      margin_q;
	logic            boot_q;
	logic [BW-1:0]   k_q, kend_q;
	logic            out_valid_q;
	logic            found_q, fast_q;
	logic [31:0]     code_q;

	logic [2:0]      mode_q;
	logic [31:0]     a_q, e_q, h_q, fu_q, min_q;
	logic [BW-1:0]   b_q;
	logic [SW-1:0]   fill_q, fav_q, rd_idx_q, chk_idx_q, min_idx_q, i_q;
	logic            chk_valid_q, wb_q;
	logic            res_found_q, res_fast_q;
	logic [31:0]     res_code_q;

	hbc_pkg::entry_t ent_rdata_q, ent_wdata;
	logic            ent_re, ent_we;
	logic [BW+WB-1:0] ent_raddr, ent_waddr;
	meta_t           meta_rdata_q, meta_wdata;
	logic            meta_re, meta_we;
	logic [BW-1:0]   meta_raddr, meta_waddr;

	logic            hash_start, hash_done;
	logic [31:0]     hash_value;
	logic [BW-1:0]   hash_bucket;

	logic            match, scan_end, ways_full, min_take, promote, in_range, out_fire;
	logic [31:0]     uses_inc;
	logic [SW-1:0]   min_idx_n, last, add_way;
	logic [BW-1:0]   k_next;

	hbc_hash #(.BUCKETS(BUCKETS), .BW(BW)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.value  (hash_value),
		.shift  (hash_shift_q),
		.done   (hash_done),
		.bucket (hash_bucket)
	);

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_waddr] <= ent_wdata;
		end
		if (ent_re) begin
			ent_rdata_q <= ent_mem[ent_raddr];
		end
		if (meta_we) begin
			meta_mem[meta_waddr] <= meta_wdata;
		end
		if (meta_re) begin
			meta_rdata_q <= meta_mem[meta_raddr];
		end
	end

	assign match = chk_valid_q && (ent_rdata_q.addr == a_q);
	assign scan_end = rd_idx_q == fill_q;
	assign ways_full = fill_q >= NONE;
	assign uses_inc = ent_rdata_q.uses + 32'd1;
	assign min_take = chk_valid_q && ((chk_idx_q == '0) || (ent_rdata_q.uses < min_q));
	assign min_idx_n = min_take ? chk_idx_q : min_idx_q;
	assign add_way = ways_full ? min_idx_n : fill_q;
	assign last = fill_q - SW'(1);
	assign promote = uses_inc > (fu_q + {24'd0, margin_q});
	assign in_range = (ent_rdata_q.addr >= a_q) && (ent_rdata_q.addr <= e_q);
	assign k_next = (k_q == BW'(BUCKETS - 1)) ? '0 : k_q + BW'(1);
	assign out_fire = (state_q == hbc_pkg::ST_DONE) && (!out_valid_q || out_ready);

	assign in_ready = state_q == hbc_pkg::ST_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign found = found_q;
	assign fast_hit = fast_q;
	assign code_out = code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hbc_pkg::ST_SWEEP;
			boot_q <= 1'b1;
			k_q <= '0;
			kend_q <= BW'(BUCKETS - 1);
			out_valid_q <= 1'b0;
			hash_shift_q <= 5'd2;
			margin_q <= 8'd2;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_index == hbc_pkg::CFG_HASH_SHIFT) begin
				hash_shift_q <= cfg_data[4:0];
			end
			if (cfg_valid && cfg_index == hbc_pkg::CFG_PROMOTE_MARGIN) begin
				margin_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (out_fire) begin
				out_valid_q <= 1'b1;
			end
			case (state_q)
				hbc_pkg::ST_HASH_A: begin
					if (hash_done && mode_q == hbc_pkg::MODE_RESET) begin
						k_q <= '0;
						kend_q <= BW'(BUCKETS - 1);
					end
				end
				hbc_pkg::ST_HASH_E: begin
					if (hash_done) begin
						k_q <= b_q;
						kend_q <= hash_bucket;
					end
				end
				hbc_pkg::ST_SWEEP: begin
					if (k_q == kend_q) begin
						boot_q <= 1'b0;
					end else begin
						k_q <= k_next;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire) begin
			found_q <= res_found_q;
			fast_q <= res_fast_q;
			code_q <= res_code_q;
		end
		case (state_q)
			hbc_pkg::ST_IDLE: begin
				if (in_valid) begin
					mode_q <= mode;
					a_q <= addr;
					e_q <= end_addr;
					h_q <= code_handle;
					wb_q <= 1'b0;
					res_found_q <= 1'b0;
					res_fast_q <= 1'b0;
					res_code_q <= '0;
				end
			end
			hbc_pkg::ST_HASH_A: begin
				if (hash_done) begin
					b_q <= hash_bucket;
				end
			end
			hbc_pkg::ST_META: begin
				fill_q <= meta_rdata_q.fill;
				fav_q <= meta_rdata_q.fav;
				wb_q <= 1'b1;
				fu_q <= '0;
				rd_idx_q <= '0;
				chk_valid_q <= 1'b0;
				i_q <= '0;
			end
			hbc_pkg::ST_FAV: begin
				if (ent_rdata_q.addr == a_q) begin
					res_found_q <= 1'b1;
					res_fast_q <= 1'b1;
					res_code_q <= ent_rdata_q.handle;
				end else begin
					fu_q <= ent_rdata_q.uses;
				end
			end
			hbc_pkg::ST_SCAN: begin
				if (match) begin
					if (mode_q == hbc_pkg::MODE_LOOKUP) begin
						res_found_q <= 1'b1;
						res_code_q <= ent_rdata_q.handle;
						if (promote) begin
							fav_q <= chk_idx_q;
						end
					end else if (mode_q == hbc_pkg::MODE_REMOVE) begin
						res_found_q <= 1'b1;
						i_q <= chk_idx_q;
					end
				end else begin
					if (min_take) begin
						min_q <= ent_rdata_q.uses;
						min_idx_q <= chk_idx_q;
					end
					if (scan_end) begin
						if (mode_q == hbc_pkg::MODE_ADD) begin
							if (!ways_full) begin
								fill_q <= fill_q + SW'(1);
							end
							fav_q <= NONE;
						end
					end else begin
						rd_idx_q <= rd_idx_q + SW'(1);
						chk_idx_q <= rd_idx_q;
						chk_valid_q <= 1'b1;
					end
				end
			end
			hbc_pkg::ST_DROP_WR: begin
				if (fav_q == i_q) begin
					fav_q <= NONE;
				end else if (i_q < last && fav_q == last) begin
					fav_q <= i_q;
				end
				fill_q <= last;
			end
			hbc_pkg::ST_INV_CHK: begin
				if (!in_range) begin
					i_q <= i_q + SW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		hash_start = 1'b0;
		hash_value = addr;
		ent_re = 1'b0;
		ent_raddr = {b_q, rd_idx_q[WB-1:0]};
		ent_we = 1'b0;
		ent_waddr = {b_q, chk_idx_q[WB-1:0]};
		ent_wdata = ent_rdata_q;
		meta_re = 1'b0;
		meta_raddr = b_q;
		meta_we = 1'b0;
		meta_waddr = b_q;
		meta_wdata = '{fill: fill_q, fav: fav_q};
		case (state_q)
			hbc_pkg::ST_IDLE: begin
				if (in_valid) begin
					hash_start = 1'b1;
					state_d = hbc_pkg::ST_HASH_A;
				end
			end
			hbc_pkg::ST_HASH_A: begin
				if (hash_done) begin
					if (mode_q == hbc_pkg::MODE_INV) begin
						hash_start = 1'b1;
						hash_value = e_q;
						state_d = hbc_pkg::ST_HASH_E;
					end else if (mode_q == hbc_pkg::MODE_RESET) begin
						state_d = hbc_pkg::ST_SWEEP;
					end else if (mode_q > hbc_pkg::MODE_RESET) begin
						state_d = hbc_pkg::ST_DONE;
					end else begin
						meta_re = 1'b1;
						meta_raddr = hash_bucket;
						state_d = hbc_pkg::ST_META;
					end
				end
			end
			hbc_pkg::ST_HASH_E: begin
				if (hash_done) begin
					if (hash_bucket == b_q) begin
						meta_re = 1'b1;
						state_d = hbc_pkg::ST_META;
					end else begin
						state_d = hbc_pkg::ST_SWEEP;
					end
				end
			end
			hbc_pkg::ST_META: begin
				case (mode_q)
					hbc_pkg::MODE_LOOKUP: begin
						if (meta_rdata_q.fav < meta_rdata_q.fill) begin
							ent_re = 1'b1;
							ent_raddr = {b_q, meta_rdata_q.fav[WB-1:0]};
							state_d = hbc_pkg::ST_FAV;
						end else begin
							state_d = hbc_pkg::ST_SCAN;
						end
					end
					hbc_pkg::MODE_ADD, hbc_pkg::MODE_REMOVE: begin
						state_d = hbc_pkg::ST_SCAN;
					end
					default: begin
						state_d = hbc_pkg::ST_INV_RD;
					end
				endcase
			end
			hbc_pkg::ST_FAV: begin
				if (ent_rdata_q.addr == a_q) begin
					ent_we = 1'b1;
					ent_waddr = {b_q, fav_q[WB-1:0]};
					ent_wdata.uses = uses_inc;
					state_d = hbc_pkg::ST_DONE;
				end else begin
					state_d = hbc_pkg::ST_SCAN;
				end
			end
			hbc_pkg::ST_SCAN: begin
				if (match) begin
					case (mode_q)
						hbc_pkg::MODE_LOOKUP: begin
							ent_we = 1'b1;
							ent_wdata.uses = uses_inc;
							state_d = hbc_pkg::ST_DONE;
						end
						hbc_pkg::MODE_ADD: begin
							ent_we = 1'b1;
							ent_wdata = '{addr: a_q, handle: h_q, uses: 32'd0};
							state_d = hbc_pkg::ST_DONE;
						end
						default: begin
							state_d = hbc_pkg::ST_DROP_RD;
						end
					endcase
				end else if (scan_end) begin
					if (mode_q == hbc_pkg::MODE_ADD) begin
						ent_we = 1'b1;
						ent_waddr = {b_q, add_way[WB-1:0]};
						ent_wdata = '{addr: a_q, handle: h_q, uses: 32'd0};
					end
					state_d = hbc_pkg::ST_DONE;
				end else begin
					ent_re = 1'b1;
				end
			end
			hbc_pkg::ST_DROP_RD: begin
				ent_re = 1'b1;
				ent_raddr = {b_q, last[WB-1:0]};
				state_d = hbc_pkg::ST_DROP_WR;
			end
			hbc_pkg::ST_DROP_WR: begin
				if (i_q < last) begin
					ent_we = 1'b1;
					ent_waddr = {b_q, i_q[WB-1:0]};
				end
				state_d = (mode_q == hbc_pkg::MODE_REMOVE) ? hbc_pkg::ST_DONE :
					hbc_pkg::ST_INV_RD;
			end
			hbc_pkg::ST_INV_RD: begin
				if (i_q < fill_q) begin
					ent_re = 1'b1;
					ent_raddr = {b_q, i_q[WB-1:0]};
					state_d = hbc_pkg::ST_INV_CHK;
				end else begin
					state_d = hbc_pkg::ST_DONE;
				end
			end
			hbc_pkg::ST_INV_CHK: begin
				state_d = in_range ? hbc_pkg::ST_DROP_RD : hbc_pkg::ST_INV_RD;
			end
			hbc_pkg::ST_SWEEP: begin
				meta_we = 1'b1;
				meta_waddr = k_q;
				meta_wdata = '{fill: '0, fav: NONE};
				if (k_q == kend_q) begin
					state_d = boot_q ? hbc_pkg::ST_IDLE : hbc_pkg::ST_DONE;
				end
			end
			hbc_pkg::ST_DONE: begin
				meta_we = wb_q;
				if (!out_valid_q || out_ready) begin
					state_d = hbc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hbc_pkg::ST_IDLE;
			end
		endcase
	end

	`HBC_ASSERT_IMP(a_fast_implies_found, clk, arst_n, out_valid_q && fast_q, found_q)
	`HBC_ASSERT_IMP(a_code_implies_found, clk, arst_n, out_valid_q && code_q != 32'd0, found_q)
	`HBC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`HBC_ASSERT_IMP(a_fill_bounded, clk, arst_n, state_q == hbc_pkg::ST_SCAN, fill_q <= NONE)

endmodule
`default_nettype wire

/* tb/tb.sv */
// Testbench of hashed_block_cache_lfu_unit: directed table, then random phases at several
// register settings; each result checked against its typed row or an in-bench cache model.
// Depends on hbc_pkg and the RTL of hashed_block_cache_lfu_unit.
`default_nettype none
module tb;
	import hbc_pkg::*;

	localparam int NBUCK = 256;
	localparam int NWAY = 8;
	localparam logic [3:0] NO_FAV = 4'd8;
	localparam logic [2:0] MODE_SPARE = 3'd7;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 180;

	typedef struct packed {
		logic        found;
		logic        fast;
		logic [31:0] code;
	} lookup_res_t;

	typedef struct packed {
		logic [2:0]  m;
		logic [31:0] a;
		logic [31:0] e;
		logic [31:0] h;
		logic        typed;
		lookup_res_t r;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  mode;
	logic [31:0] addr;
	logic [31:0] end_addr;
	logic [31:0] code_handle;
	logic        out_valid;
	logic        out_ready;
	logic        found;
	logic        fast_hit;
	logic [31:0] code_out;

	hashed_block_cache_lfu_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode), .addr(addr),
		.end_addr(end_addr), .code_handle(code_handle),
		.out_valid(out_valid), .out_ready(out_ready),
		.found(found), .fast_hit(fast_hit), .code_out(code_out)
	);

	// Model of the cache contents.
	logic [4:0]  m_shift;
	logic [7:0]  m_margin;
	logic [31:0] m_addr [NBUCK*NWAY];
	logic [31:0] m_handle [NBUCK*NWAY];
	logic [31:0] m_uses [NBUCK*NWAY];
	logic [3:0]  m_fill [NBUCK];
	logic [3:0]  m_fav [NBUCK];

	lookup_res_t pending_results [$];
	int          errors = 0;
	bit          hold_req = 0;
	logic [31:0] addr_pool [12];

	function automatic logic [7:0] bucket_of(input logic [31:0] a);
		return 8'((a >> m_shift) & 32'hFF);
	endfunction

	function automatic void drop_way(input logic [7:0] b, input logic [3:0] w);
		logic [3:0] last;
		int base;
		last = m_fill[b] - 4'd1;
		base = int'(b) * NWAY;
		if (m_fav[b] == w)
			m_fav[b] = NO_FAV;
		if (w < last) begin
			m_addr[base + w] = m_addr[base + last];
			m_handle[base + w] = m_handle[base + last];
			m_uses[base + w] = m_uses[base + last];
			if (m_fav[b] == last)
				m_fav[b] = w;
		end
		m_fill[b] = last;
	endfunction

	function automatic lookup_res_t cache_predict(input logic [2:0] m, input logic [31:0] a,
			input logic [31:0] e, input logic [31:0] h);
		lookup_res_t r;
		logic [7:0] b;
		logic [7:0] eb;
		logic [3:0] fav;
		logic [3:0] fl;
		logic [31:0] lim;
		logic [31:0] mn;
		int base;
		int w;
		int i;
		bit done;
		r = '0;
		b = bucket_of(a);
		base = int'(b) * NWAY;
		fl = m_fill[b];
		fav = m_fav[b];
		done = 0;
		case (m)
			MODE_LOOKUP: begin
				if (fav < fl && m_addr[base + fav] == a) begin
					m_uses[base + fav] += 1;
					r = '{1'b1, 1'b1, m_handle[base + fav]};
				end else begin
					for (i = 0; i < fl && !done; i++) begin
						if (m_addr[base + i] == a) begin
							lim = ((fav < fl) ? m_uses[base + fav] : 32'd0) + 32'(m_margin);
							m_uses[base + i] += 1;
							if (m_uses[base + i] > lim)
								m_fav[b] = 4'(i);
							r = '{1'b1, 1'b0, m_handle[base + i]};
							done = 1;
						end
					end
				end
			end
			MODE_ADD: begin
				for (i = 0; i < fl && !done; i++) begin
					if (m_addr[base + i] == a) begin
						m_handle[base + i] = h;
						m_uses[base + i] = 0;
						done = 1;
					end
				end
				if (!done) begin
					if (fl >= NWAY) begin
						mn = m_uses[base];
						w = 0;
						for (i = 1; i < NWAY; i++) begin
							if (m_uses[base + i] < mn) begin
								mn = m_uses[base + i];
								w = i;
							end
						end
					end else begin
						w = fl;
						m_fill[b] = fl + 4'd1;
					end
					m_addr[base + w] = a;
					m_handle[base + w] = h;
					m_uses[base + w] = 0;
					m_fav[b] = NO_FAV;
				end
			end
			MODE_REMOVE: begin
				for (i = 0; i < fl && !done; i++) begin
					if (m_addr[base + i] == a) begin
						drop_way(b, 4'(i));
						r.found = 1'b1;
						done = 1;
					end
				end
			end
			MODE_INV: begin
				eb = bucket_of(e);
				if (b == eb) begin
					i = 0;
					while (i < m_fill[b]) begin
						if (m_addr[base + i] >= a && m_addr[base + i] <= e)
							drop_way(b, 4'(i));
						else
							i++;
					end
				end else begin
					forever begin
						m_fill[b] = 0;
						m_fav[b] = NO_FAV;
						if (b == eb)
							break;
						b = b + 8'd1;
					end
				end
			end
			MODE_RESET: begin
				for (i = 0; i < NBUCK; i++) begin
					m_fill[i] = 0;
					m_fav[i] = NO_FAV;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic send_word(input logic [2:0] m, input logic [31:0] a, input logic [31:0] e,
			input logic [31:0] h, input bit typed, input lookup_res_t exp_r);
		lookup_res_t r;
		in_valid <= 1'b1;
		mode <= m;
		addr <= a;
		end_addr <= e;
		code_handle <= h;
		do @(posedge clk); while (!in_ready);
		r = cache_predict(m, a, e, h);
		pending_results.push_back(typed ? exp_r : r);
	endtask

	task automatic write_reg(input logic [3:0] idx, input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_HASH_SHIFT)
			m_shift = data[4:0];
		else if (idx == CFG_PROMOTE_MARGIN)
			m_margin = data;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] make_addr();
		logic [31:0] bk;
		bk = 32'($urandom_range(0, 3));
		if ($urandom_range(0, 7) == 0)
			bk = 32'hFF;
		return ($urandom & ~(32'hFF << m_shift)) | (bk << m_shift);
	endfunction

	task automatic random_word();
		int sel;
		logic [31:0] a;
		logic [31:0] e;
		sel = $urandom_range(0, 99);
		a = addr_pool[$urandom_range(0, 11)];
		e = $urandom_range(0, 1) ? a + 32'($urandom_range(0, 64) << m_shift)
			: addr_pool[$urandom_range(0, 11)];
		if (sel < 45)
			send_word(MODE_LOOKUP, a, $urandom, $urandom, 0, '0);
		else if (sel < 70)
			send_word(MODE_ADD, a, $urandom, $urandom, 0, '0);
		else if (sel < 84)
			send_word(MODE_REMOVE, a, $urandom, $urandom, 0, '0);
		else if (sel < 92)
			send_word(MODE_INV, a, e, $urandom, 0, '0);
		else if (sel < 94)
			send_word(MODE_RESET, $urandom, $urandom, $urandom, 0, '0);
		else
			send_word(3'($urandom), $urandom, $urandom, $urandom, 0, '0);
	endtask

	dir_row_t dir_tab [30];

	initial begin
		int n;
		int burst;
		logic [4:0] sh;
		logic [7:0] mg;
		dir_tab = '{
			'{MODE_LOOKUP, 32'h0, 32'h0, 32'h0, 1'b1, '{1'b0, 1'b0, 32'h0}},
			'{MODE_ADD, 32'h10, 32'h0, 32'hFFFFFFFF, 1'b1, '{1'b0, 1'b0, 32'h0}},
			'{MODE_LOOKUP, 32'h10, 32'h0, 32'h0, 1'b1, '{1'b1, 1'b0, 32'hFFFFFFFF}},
			'{MODE_LOOKUP, 32'h10, 32'h0, 32'h0, 1'b1, '{1'b1, 1'b0, 32'hFFFFFFFF}},
			'{MODE_LOOKUP, 32'h10, 32'h0, 32'h0, 1'b1, '{1'b1, 1'b0, 32'hFFFFFFFF}},
			'{MODE_LOOKUP, 32'h10, 32'h0, 32'h0, 1'b1, '{1'b1, 1'b1, 32'hFFFFFFFF}},
			'{MODE_ADD, 32'h10, 32'h0, 32'h0, 1'b1, '{1'b0, 1'b0, 32'h0}},
			'{MODE_LOOKUP, 32'h10, 32'h0, 32'h0, 1'b1, '{1'b1, 1'b1, 32'h0}},
			'{MODE_REMOVE, 32'h10, 32'h0, 32'h0, 1'b1, '{1'b1, 1'b0, 32'h0}},
			'{MODE_REMOVE, 32'h10, 32'h0, 32'h0, 1'b1, '{1'b0, 1'b0, 32'h0}},
			'{MODE_ADD, 32'hFFFFFFFF, 32'h0, 32'h12345678, 1'b1, '{1'b0, 1'b0, 32'h0}},
			'{MODE_LOOKUP, 32'hFFFFFFFF, 32'h0, 32'h0, 1'b1, '{1'b1, 1'b0, 32'h12345678}},
			'{MODE_INV, 32'hFFFFFFF0, 32'hFFFFFFFF, 32'h0, 1'b1, '{1'b0, 1'b0, 32'h0}},
			'{MODE_LOOKUP, 32'hFFFFFFFF, 32'h0, 32'h0, 1'b1, '{1'b0, 1'b0, 32'h0}},
			'{MODE_ADD, 32'h0000, 32'h0, 32'hA0, 1'b0, '0},
			'{MODE_ADD, 32'h0400, 32'h0, 32'hA1, 1'b0, '0},
			'{MODE_ADD, 32'h0800, 32'h0, 32'hA2, 1'b0, '0},
			'{MODE_ADD, 32'h0C00, 32'h0, 32'hA3, 1'b0, '0},
			'{MODE_ADD, 32'h1000, 32'h0, 32'hA4, 1'b0, '0},
			'{MODE_ADD, 32'h1400, 32'h0, 32'hA5, 1'b0, '0},
			'{MODE_ADD, 32'h1800, 32'h0, 32'hA6, 1'b0, '0},
			'{MODE_ADD, 32'h1C00, 32'h0, 32'hA7, 1'b0, '0},
			'{MODE_ADD, 32'h2000, 32'h0, 32'hA8, 1'b0, '0},
			'{MODE_LOOKUP, 32'h2000, 32'h0, 32'h0, 1'b0, '0},
			'{MODE_LOOKUP, 32'h0000, 32'h0, 32'h0, 1'b0, '0},
			'{MODE_INV, 32'h0400, 32'h1000, 32'h0, 1'b0, '0},
			'{MODE_INV, 32'h3000, 32'h0, 32'h0, 1'b0, '0},
			'{MODE_SPARE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '{1'b0, 1'b0, 32'h0}},
			'{MODE_RESET, 32'h0, 32'h0, 32'h0, 1'b1, '{1'b0, 1'b0, 32'h0}},
			'{MODE_LOOKUP, 32'h0800, 32'h0, 32'h0, 1'b1, '{1'b0, 1'b0, 32'h0}}
		};
		m_shift = 5'd2;
		m_margin = 8'd2;
		for (int i = 0; i < NBUCK; i++) begin
			m_fill[i] = 0;
			m_fav[i] = NO_FAV;
		end
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		mode <= '0;
		addr <= '0;
		end_addr <= '0;
		code_handle <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_word(dir_tab[i].m, dir_tab[i].a, dir_tab[i].e, dir_tab[i].h,
				dir_tab[i].typed, dir_tab[i].r);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin sh = 5'd0; mg = 8'd0; end
				1: begin sh = 5'd31; mg = 8'd255; end
				2: begin sh = 5'd2; mg = 8'd2; end
				default: begin sh = 5'($urandom_range(0, 12)); mg = 8'($urandom_range(0, 6)); end
			endcase
			write_reg(CFG_HASH_SHIFT, {3'($urandom), sh});
			write_reg(CFG_PROMOTE_MARGIN, mg);
			foreach (addr_pool[i])
				addr_pool[i] = make_addr();
			n = 0;
			while (n < PHASE_ITEMS) begin
				burst = $urandom_range(1, 24);
				for (int k = 0; k < burst && n < PHASE_ITEMS; k++) begin
					random_word();
					n++;
					if (ph == 1 && n == 60)
						hold_req = 1;
				end
				if (ph == 2 && n >= 90 && n < 90 + burst) begin
					in_valid <= 1'b0;
					while (pending_results.size() != 0)
						@(posedge clk);
				end else if ($urandom_range(0, 3) != 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 12)) @(posedge clk);
				end
			end
			drain();
		end
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int cnt;
		int pat;
		cnt = 0;
		pat = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 0;
			end else begin
				cnt++;
				if (cnt % 97 == 0)
					pat = $urandom_range(0, 2);
				case (pat)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		lookup_res_t x;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected word found=%b fast_hit=%b code_out=%h",
					$time, found, fast_hit, code_out);
				errors++;
			end else begin
				x = pending_results.pop_front();
				if (found !== x.found) begin
					$display("%0t: found expected %b actual %b", $time, x.found, found);
					errors++;
				end
				if (fast_hit !== x.fast) begin
					$display("%0t: fast_hit expected %b actual %b", $time, x.fast, fast_hit);
					errors++;
				end
				if (code_out !== x.code) begin
					$display("%0t: code_out expected %h actual %h", $time, x.code, code_out);
					errors++;
				end
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
			if (idle >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

endmodule
`default_nettype wire
